// ===== sv/rhc_pkg.sv =====
package rhc_pkg;

    // field widths fixed by the item format
    localparam int MODE_W   = 3;
    localparam int FRAC_W   = 17;
    localparam int POINT_W  = 32;
    localparam int NORMAL_W = 18;
    localparam int ENTITY_W = 32;
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 2;

    // fraction constants, Q1.16
    localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_EMPTY = 17'h1FFFF;

    // item modes
    localparam logic [MODE_W-1:0] MODE_ANY      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSEST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MULTIPLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SORTED   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;

    // answers to the ray caster
    localparam logic [ACTION_W-1:0] ACT_SKIP      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TERMINATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLIP      = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CONTINUE  = 2'd3;

    // limit a fraction to one
    function automatic logic [FRAC_W-1:0] sat_one(input logic [FRAC_W-1:0] f);
        sat_one = (f > FRAC_ONE) ? FRAC_ONE : f;
    endfunction

endpackage

// ===== sv/ray_hit_collector.sv =====
// channel   | ports                                              | handshake
// ----------+----------------------------------------------------+-------------------------
// hit in    | mode new_ray ignore hit_x hit_y normal_x normal_y  | start high, busy low
//           | hit_fraction entity_id                             |
// result    | action clip_fraction hit_count slot out_x out_y    | result_strobe, one cycle
//           | out_normal_x out_normal_y out_fraction out_entity  |
//           | last                                               |
//
// one item at a time through a small sequencer around a single scan comparator
// accept to next accept: any, closest, multiple and skip pass only through dispatch;
// read-out then streams the kept hits; sorted ends after the scan if not closer, else
// shifts and reports, one slot per cycle through the shared comparator and slot port
// reset clears the kept count, marks every slot fraction empty and zeroes slot data
// the receiver cannot stall: each result is shown for exactly one cycle
module ray_hit_collector
    import rhc_pkg::*;
#(
    parameter int SLOTS = 3
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [MODE_W-1:0]          mode,
    input  logic                       new_ray,
    input  logic                       ignore,
    input  logic signed [POINT_W-1:0]  hit_x,
    input  logic signed [POINT_W-1:0]  hit_y,
    input  logic signed [NORMAL_W-1:0] normal_x,
    input  logic signed [NORMAL_W-1:0] normal_y,
    input  logic [FRAC_W-1:0]          hit_fraction,
    input  logic [ENTITY_W-1:0]        entity_id,
    output logic                       result_strobe,
    output logic [ACTION_W-1:0]        action,
    output logic [FRAC_W-1:0]          clip_fraction,
    output logic [COUNT_W-1:0]         hit_count,
    output logic [COUNT_W-1:0]         slot,
    output logic signed [POINT_W-1:0]  out_x,
    output logic signed [POINT_W-1:0]  out_y,
    output logic signed [NORMAL_W-1:0] out_normal_x,
    output logic signed [NORMAL_W-1:0] out_normal_y,
    output logic [FRAC_W-1:0]          out_fraction,
    output logic [ENTITY_W-1:0]        out_entity,
    output logic                       last
);

    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0]  SLOTS_C = IDX_W'(SLOTS);
    localparam logic [SLOT_W-1:0] TOP_C   = SLOT_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_SHIFT,
        ST_REPORT,
        ST_READ
    } state_t;

    state_t state_reg;

    // slot store
    logic [FRAC_W-1:0]          frac_reg   [SLOTS];
    logic signed [POINT_W-1:0]  px_reg     [SLOTS];
    logic signed [POINT_W-1:0]  py_reg     [SLOTS];
    logic signed [NORMAL_W-1:0] nx_reg     [SLOTS];
    logic signed [NORMAL_W-1:0] ny_reg     [SLOTS];
    logic [ENTITY_W-1:0]        entity_reg [SLOTS];
    logic [IDX_W-1:0]           count_reg;

    // latched item
    logic [MODE_W-1:0]          mode_reg;
    logic                       ignore_reg;
    logic signed [POINT_W-1:0]  x_reg;
    logic signed [POINT_W-1:0]  y_reg;
    logic signed [NORMAL_W-1:0] nrm_x_reg;
    logic signed [NORMAL_W-1:0] nrm_y_reg;
    logic [FRAC_W-1:0]          f_reg;
    logic [ENTITY_W-1:0]        id_reg;

    // sequencer counters
    logic [IDX_W-1:0]  idx_reg;
    logic [SLOT_W-1:0] j_reg;

    // registered result
    logic                 strobe_reg;
    logic [ACTION_W-1:0]  action_reg;
    logic [FRAC_W-1:0]    clip_reg;
    logic [COUNT_W-1:0]   hit_count_reg;
    logic [COUNT_W-1:0]   slot_out_reg;
    logic signed [POINT_W-1:0]  ox_reg;
    logic signed [POINT_W-1:0]  oy_reg;
    logic signed [NORMAL_W-1:0] onx_reg;
    logic signed [NORMAL_W-1:0] ony_reg;
    logic [FRAC_W-1:0]    ofrac_reg;
    logic [ENTITY_W-1:0]  oent_reg;
    logic                 last_reg;

    // shared comparator and index arithmetic
    logic [IDX_W-1:0]  idx_m1;
    logic [SLOT_W-1:0] j_m1;
    logic [IDX_W-1:0]  count_inc;
    logic [IDX_W-1:0]  count_m1;
    logic [FRAC_W-1:0] scan_frac;
    logic              closer;
    logic [SLOT_W-1:0] idx_sel;
    logic [SLOT_W-1:0] rd_sel;

    assign idx_m1    = idx_reg - 1'b1;
    assign j_m1      = j_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign count_m1  = count_reg - 1'b1;
    assign idx_sel   = idx_reg[SLOT_W-1:0];
    assign rd_sel    = idx_reg[SLOT_W-1:0];
    assign scan_frac = frac_reg[idx_m1[SLOT_W-1:0]];
    assign closer    = (idx_reg != '0) && (f_reg < scan_frac);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            strobe_reg    <= 1'b0;
            action_reg    <= ACT_SKIP;
            clip_reg      <= '0;
            hit_count_reg <= '0;
            slot_out_reg  <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            onx_reg       <= '0;
            ony_reg       <= '0;
            ofrac_reg     <= '0;
            oent_reg      <= '0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            j_reg         <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                frac_reg[i]   <= FRAC_EMPTY;
                px_reg[i]     <= '0;
                py_reg[i]     <= '0;
                nx_reg[i]     <= '0;
                ny_reg[i]     <= '0;
                entity_reg[i] <= '0;
            end
        end
        else
        begin
            // result defaults: no strobe, data zero, hit count from the kept count, last set
            strobe_reg    <= 1'b0;
            action_reg    <= ACT_SKIP;
            clip_reg      <= '0;
            hit_count_reg <= COUNT_W'(count_reg);
            slot_out_reg  <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            onx_reg       <= '0;
            ony_reg       <= '0;
            ofrac_reg     <= '0;
            oent_reg      <= '0;
            last_reg      <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    // take an item, clear the ray first when asked
                    if (start)
                    begin
                        mode_reg   <= mode;
                        ignore_reg <= ignore;
                        x_reg      <= hit_x;
                        y_reg      <= hit_y;
                        nrm_x_reg  <= normal_x;
                        nrm_y_reg  <= normal_y;
                        f_reg      <= sat_one(hit_fraction);
                        id_reg     <= entity_id;
                        if (new_ray)
                        begin
                            count_reg <= '0;
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                frac_reg[i] <= FRAC_EMPTY;
                            end
                        end
                        state_reg <= ST_DISPATCH;
                    end
                end

                ST_DISPATCH:
                begin
                    if (mode_reg == MODE_READ)
                    begin
                        // read-out: an empty buffer gives one blank result
                        idx_reg <= '0;
                        if (count_reg == '0)
                        begin
                            strobe_reg <= 1'b1;
                            state_reg  <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                    else if (ignore_reg || mode_reg > MODE_READ)
                    begin
                        strobe_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else if (mode_reg inside {MODE_ANY, MODE_CLOSEST})
                    begin
                        // keep in slot 0
                        frac_reg[0]   <= f_reg;
                        px_reg[0]     <= x_reg;
                        py_reg[0]     <= y_reg;
                        nx_reg[0]     <= nrm_x_reg;
                        ny_reg[0]     <= nrm_y_reg;
                        entity_reg[0] <= id_reg;
                        count_reg     <= IDX_W'(1);
                        hit_count_reg <= COUNT_W'(1);
                        strobe_reg    <= 1'b1;
                        if (mode_reg == MODE_ANY)
                        begin
                            action_reg <= ACT_TERMINATE;
                        end
                        else
                        begin
                            action_reg <= ACT_CLIP;
                            clip_reg   <= f_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else if (mode_reg == MODE_MULTIPLE)
                    begin
                        // append until full, drop when full
                        strobe_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                        if (count_reg >= SLOTS_C)
                        begin
                            count_reg     <= SLOTS_C;
                            hit_count_reg <= COUNT_W'(SLOTS_C);
                            action_reg    <= ACT_TERMINATE;
                        end
                        else
                        begin
                            frac_reg[count_reg[SLOT_W-1:0]]   <= f_reg;
                            px_reg[count_reg[SLOT_W-1:0]]     <= x_reg;
                            py_reg[count_reg[SLOT_W-1:0]]     <= y_reg;
                            nx_reg[count_reg[SLOT_W-1:0]]     <= nrm_x_reg;
                            ny_reg[count_reg[SLOT_W-1:0]]     <= nrm_y_reg;
                            entity_reg[count_reg[SLOT_W-1:0]] <= id_reg;
                            count_reg     <= count_inc;
                            hit_count_reg <= COUNT_W'(count_inc);
                            slot_out_reg  <= COUNT_W'(count_reg);
                            if (count_inc == SLOTS_C)
                            begin
                                action_reg <= ACT_TERMINATE;
                            end
                            else
                            begin
                                action_reg <= ACT_CONTINUE;
                                clip_reg   <= FRAC_ONE;
                            end
                        end
                    end
                    else
                    begin
                        // sorted: scan down from the top slot
                        idx_reg   <= SLOTS_C;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    // one slot compared per cycle
                    if (closer)
                    begin
                        idx_reg <= idx_m1;
                    end
                    else if (idx_reg == SLOTS_C)
                    begin
                        strobe_reg <= 1'b1;
                        action_reg <= ACT_CLIP;
                        clip_reg   <= sat_one(frac_reg[TOP_C]);
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        j_reg     <= TOP_C;
                        state_reg <= ST_SHIFT;
                    end
                end

                ST_SHIFT:
                begin
                    // move one slot up per cycle, then write the hit
                    if (IDX_W'(j_reg) > idx_reg)
                    begin
                        frac_reg[j_reg]   <= frac_reg[j_m1];
                        px_reg[j_reg]     <= px_reg[j_m1];
                        py_reg[j_reg]     <= py_reg[j_m1];
                        nx_reg[j_reg]     <= nx_reg[j_m1];
                        ny_reg[j_reg]     <= ny_reg[j_m1];
                        entity_reg[j_reg] <= entity_reg[j_m1];
                        j_reg             <= j_m1;
                    end
                    else
                    begin
                        frac_reg[idx_sel]   <= f_reg;
                        px_reg[idx_sel]     <= x_reg;
                        py_reg[idx_sel]     <= y_reg;
                        nx_reg[idx_sel]     <= nrm_x_reg;
                        ny_reg[idx_sel]     <= nrm_y_reg;
                        entity_reg[idx_sel] <= id_reg;
                        count_reg <= (count_reg < SLOTS_C) ? count_inc : SLOTS_C;
                        state_reg <= ST_REPORT;
                    end
                end

                ST_REPORT:
                begin
                    // answer from the updated slots
                    strobe_reg   <= 1'b1;
                    slot_out_reg <= COUNT_W'(idx_reg);
                    if (count_reg == SLOTS_C)
                    begin
                        action_reg <= ACT_CLIP;
                        clip_reg   <= sat_one(frac_reg[TOP_C]);
                    end
                    else
                    begin
                        action_reg <= ACT_CONTINUE;
                        clip_reg   <= FRAC_ONE;
                    end
                    state_reg <= ST_IDLE;
                end

                ST_READ:
                begin
                    // stream one kept slot per cycle
                    strobe_reg   <= 1'b1;
                    slot_out_reg <= COUNT_W'(idx_reg);
                    ox_reg       <= px_reg[rd_sel];
                    oy_reg       <= py_reg[rd_sel];
                    onx_reg      <= nx_reg[rd_sel];
                    ony_reg      <= ny_reg[rd_sel];
                    ofrac_reg    <= frac_reg[rd_sel];
                    oent_reg     <= entity_reg[rd_sel];
                    last_reg     <= (idx_reg == count_m1);
                    if (idx_reg == count_m1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ports
    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign action        = action_reg;
    assign clip_fraction = clip_reg;
    assign hit_count     = hit_count_reg;
    assign slot          = slot_out_reg;
    assign out_x         = ox_reg;
    assign out_y         = oy_reg;
    assign out_normal_x  = onx_reg;
    assign out_normal_y  = ony_reg;
    assign out_fraction  = ofrac_reg;
    assign out_entity    = oent_reg;
    assign last          = last_reg;

endmodule
